### hw/rtl/io_port_permission_table_assert.svh
// ----------------------------------------------------------------------------
// io_port_permission_table assertion macros
// Implication checks, same cycle and next cycle, sampled on the clock.
// ----------------------------------------------------------------------------
`ifndef IO_PORT_PERMISSION_TABLE_ASSERT_SVH
`define IO_PORT_PERMISSION_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define IOPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IOPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/iopt_pkg.sv
// ----------------------------------------------------------------------------
// iopt_pkg
// Types and constants of the I/O port permission table.
// ----------------------------------------------------------------------------
package iopt_pkg;

   localparam int PORT_W       = 16;
   localparam int COUNT_W      = 17;
   localparam int CAP_W        = 16;
   localparam int TASK_IN_W    = 4;
   localparam int BITMAP_BYTES = 8192;
   localparam int WORD_BITS    = 64;
   localparam int WORD_IDX_W   = 6;
   localparam int WORDS_PER_SLOT = BITMAP_BYTES * 8 / WORD_BITS;
   localparam int WORD_ADDR_W  = 10;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 16;
   localparam logic [4:0] TOTAL_MAX = 5'd31;
   localparam logic [PORT_W-1:0] PORT_LAST = 16'hFFFF;

   typedef enum logic [3:0] {
      OP_CLAIM   = 4'd0,
      OP_RELEASE = 4'd1,
      OP_GRANT   = 4'd2,
      OP_SWITCH  = 4'd3,
      OP_CHECK   = 4'd4,
      OP_ADD     = 4'd5,
      OP_REVOKE  = 4'd6,
      OP_DROP    = 4'd7,
      OP_COUNT   = 4'd8,
      OP_RESET   = 4'd9
   } op_type;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_MASK = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [PORT_W-1:0]    start;
      logic [CAP_W-1:0]     cap;
      logic [TASK_IN_W-1:0] owner;
   } ledger_entry_type;

   localparam int LEDGER_W = $bits(ledger_entry_type);

endpackage

### hw/rtl/iopt_ram.sv
// ----------------------------------------------------------------------------
// iopt_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module iopt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/io_port_permission_table.sv
// ----------------------------------------------------------------------------
// io_port_permission_table
// Per-task I/O port permission bitmaps with slot pool and grant ledger.
// ----------------------------------------------------------------------------
// Usage: one request channel (req_*) carries an operation per transaction and
// one response channel (rsp_*) returns exactly one result per request, in
// order. The block takes one request at a time: req_tready is high only while
// the sequencer is idle. The result sits in an output register, so a new
// request is taken while a result still waits on rsp_tready; the sequencer
// holds its next result until that register frees up.
// Simple operations pass from a dispatch state to the done state, which loads
// the response register. A claim scans the slots one a cycle, then fills
// 1024 64-bit words. A grant does a read-modify-write of each 64-bit word
// touched, in a read state and then a write state. Revoke, drop and count
// read each ledger entry, check it and step on; a revoke adds a range set-up
// state plus a read and a write of each word for each matching range.
// Reset clears the claim mask, slot table, loaded owner and ledger valid bits
// at once; bitmap contents need no clearing since a claim fills its slot.
// ----------------------------------------------------------------------------
`include "io_port_permission_table_assert.svh"

module io_port_permission_table #(
   parameter int NUM_SLOTS  = 8,
   parameter int NUM_GRANTS = 16,
   parameter int NUM_TASKS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[3:0], task_id[7:4], user_mode[8], port_start[24:9],
   // port_count[41:25], cap_id[57:42], zero fill
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], grant_total[5:1], owner_loaded[10:6], tss_action[12:11],
   // tss_slot[15:13]
   output logic [15:0] rsp_tdata
);

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int GRANT_W = (NUM_GRANTS > 1) ? $clog2(NUM_GRANTS) : 1;
   localparam int TASK_W  = $clog2(NUM_TASKS);
   localparam int OWN_W   = $clog2(NUM_TASKS + 1);
   localparam int BM_DEPTH  = (1 << SLOT_W) * iopt_pkg::WORDS_PER_SLOT;
   localparam int BM_ADDR_W = SLOT_W + iopt_pkg::WORD_ADDR_W;
   localparam logic [OWN_W-1:0]   OWNER_NONE = OWN_W'(NUM_TASKS);
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [GRANT_W-1:0] GRANT_LAST = GRANT_W'(NUM_GRANTS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_CLAIM_SCAN, S_FILL, S_CHECK, S_ADD_SCAN,
      S_LSCAN_RD, S_LSCAN_CHK, S_LSCAN_NEXT, S_RANGE_INIT, S_RANGE_RD,
      S_RANGE_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [3:0]  op_ff, op_in;
   logic [3:0]  task_ff, task_in;
   logic        user_ff, user_in;
   logic [15:0] start_ff, start_in;
   logic [16:0] count_ff, count_in;
   logic [15:0] cap_ff, cap_in;

   // persistent state
   logic [NUM_SLOTS-1:0]  claimed_ff, claimed_in;
   logic                  ts_valid_ff [NUM_TASKS];
   logic                  ts_valid_in [NUM_TASKS];
   logic [SLOT_W-1:0]     ts_slot_ff  [NUM_TASKS];
   logic [SLOT_W-1:0]     ts_slot_in  [NUM_TASKS];
   logic [OWN_W-1:0]      owner_ff, owner_in;
   logic [NUM_GRANTS-1:0] active_ff, active_in;

   // sequencer working registers
   logic [SLOT_W-1:0]  sidx_ff, sidx_in;
   logic [GRANT_W-1:0] gidx_ff, gidx_in;
   logic [iopt_pkg::WORD_ADDR_W-1:0] fword_ff, fword_in;
   logic [SLOT_W-1:0]  rs_slot_ff, rs_slot_in;
   logic [15:0]        rs_start_ff, rs_start_in;
   logic [16:0]        rs_count_ff, rs_count_in;
   logic               rs_deny_ff, rs_deny_in;
   logic [15:0]        rs_last_ff, rs_last_in;
   logic [iopt_pkg::WORD_ADDR_W-1:0] rs_word_ff, rs_word_in;
   logic               reload_ff, reload_in;
   logic [SLOT_W-1:0]  reload_slot_ff, reload_slot_in;

   // result being built and output register
   logic       ok_ff, ok_in;
   logic [4:0] total_ff, total_in;
   logic [1:0] action_ff, action_in;
   logic [2:0] tslot_ff, tslot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // memories
   logic                 bm_we;
   logic [BM_ADDR_W-1:0] bm_waddr, bm_raddr;
   logic [63:0]          bm_wdata, bm_rdata;
   logic                 lg_we;
   logic [GRANT_W-1:0]   lg_waddr;
   iopt_pkg::ledger_entry_type lg_wdata, lg_rdata;
   logic [iopt_pkg::LEDGER_W-1:0] lg_rdata_raw;

   // slot table lookup, one port
   logic [3:0]        lk_tid;
   logic              lk_in_range;
   logic [TASK_W-1:0] lk_idx;
   logic              lk_valid;
   logic [SLOT_W-1:0] lk_slot;
   logic              lk_is_owner;
   logic              t_in_range;
   logic [TASK_W-1:0] t_idx;

   logic [17:0] rs_sum;
   logic [5:0]  rs_lo, rs_hi;
   logic [63:0] rs_mask;
   logic        accept;

   iopt_ram #(.WIDTH(64), .DEPTH(BM_DEPTH)) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   iopt_ram #(.WIDTH(iopt_pkg::LEDGER_W), .DEPTH(1 << GRANT_W)) u_ledger (
      .clock (clock),
      .we    (lg_we),
      .waddr (lg_waddr),
      .wdata (lg_wdata),
      .raddr (gidx_ff),
      .rdata (lg_rdata_raw)
   );

   assign lg_rdata = iopt_pkg::ledger_entry_type'(lg_rdata_raw);

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign t_in_range = (9'(task_ff) < 9'(NUM_TASKS));
   assign t_idx      = t_in_range ? TASK_W'(task_ff) : '0;

   // during the ledger check the lookup follows the entry owner
   assign lk_tid      = (state_ff == S_LSCAN_CHK) ? lg_rdata.owner : task_ff;
   assign lk_in_range = (9'(lk_tid) < 9'(NUM_TASKS));
   assign lk_idx      = lk_in_range ? TASK_W'(lk_tid) : '0;
   assign lk_slot     = ts_slot_ff[lk_idx];
   assign lk_valid    = lk_in_range && ts_valid_ff[lk_idx] && claimed_ff[lk_slot];
   assign lk_is_owner = (9'(owner_ff) == 9'(lk_tid));

   assign rs_sum  = {2'b00, rs_start_ff} + {1'b0, rs_count_ff} - 18'd1;
   assign rs_lo   = (rs_word_ff == rs_start_ff[15:6]) ? rs_start_ff[5:0] : 6'd0;
   assign rs_hi   = (rs_word_ff == rs_last_ff[15:6]) ? rs_last_ff[5:0] : 6'd63;
   assign rs_mask = ({64{1'b1}} << rs_lo) & ({64{1'b1}} >> (6'd63 - rs_hi));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      task_in        = task_ff;
      user_in        = user_ff;
      start_in       = start_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      claimed_in     = claimed_ff;
      ts_valid_in    = ts_valid_ff;
      ts_slot_in     = ts_slot_ff;
      owner_in       = owner_ff;
      active_in      = active_ff;
      sidx_in        = sidx_ff;
      gidx_in        = gidx_ff;
      fword_in       = fword_ff;
      rs_slot_in     = rs_slot_ff;
      rs_start_in    = rs_start_ff;
      rs_count_in    = rs_count_ff;
      rs_deny_in     = rs_deny_ff;
      rs_last_in     = rs_last_ff;
      rs_word_in     = rs_word_ff;
      reload_in      = reload_ff;
      reload_slot_in = reload_slot_ff;
      ok_in          = ok_ff;
      total_in       = total_ff;
      action_in      = action_ff;
      tslot_in       = tslot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      bm_we          = 1'b0;
      bm_waddr       = {rs_slot_ff, rs_word_ff};
      bm_wdata       = bm_rdata;
      bm_raddr       = {rs_slot_ff, rs_word_ff};
      lg_we          = 1'b0;
      lg_waddr       = gidx_ff;
      lg_wdata       = '{count: count_ff, start: start_ff, cap: cap_ff, owner: task_ff};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tdata[3:0];
               task_in   = req_tdata[7:4];
               user_in   = req_tdata[8];
               start_in  = req_tdata[24:9];
               count_in  = req_tdata[41:25];
               cap_in    = req_tdata[57:42];
               ok_in     = 1'b0;
               total_in  = 5'd0;
               action_in = iopt_pkg::ACT_NONE;
               tslot_in  = 3'd0;
               reload_in = 1'b0;
               sidx_in   = '0;
               gidx_in   = '0;
               fword_in  = '0;
               state_in  = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in = S_DONE;
            unique case (op_ff)
               iopt_pkg::OP_CLAIM: begin
                  if (lk_valid) begin
                     ok_in = 1'b1;
                  end else if (t_in_range) begin
                     state_in = S_CLAIM_SCAN;
                  end
               end
               iopt_pkg::OP_RELEASE: begin
                  if (t_in_range && ts_valid_ff[t_idx]) begin
                     claimed_in[ts_slot_ff[t_idx]] = 1'b0;
                     if (lk_is_owner) begin
                        action_in = iopt_pkg::ACT_MASK;
                        owner_in  = OWNER_NONE;
                     end
                     ts_valid_in[t_idx] = 1'b0;
                     ts_slot_in[t_idx]  = '0;
                  end
               end
               iopt_pkg::OP_GRANT: begin
                  if (lk_valid) begin
                     ok_in       = 1'b1;
                     rs_slot_in  = lk_slot;
                     rs_start_in = start_ff;
                     rs_count_in = count_ff;
                     rs_deny_in  = 1'b0;
                     if (lk_is_owner) begin
                        action_in = iopt_pkg::ACT_LOAD;
                        tslot_in  = 3'(lk_slot);
                     end
                     state_in = S_RANGE_INIT;
                  end
               end
               iopt_pkg::OP_SWITCH: begin
                  if (user_ff) begin
                     if (lk_valid) begin
                        if (!lk_is_owner) begin
                           action_in = iopt_pkg::ACT_LOAD;
                           tslot_in  = 3'(lk_slot);
                           owner_in  = OWN_W'(task_ff);
                        end
                     end else if (owner_ff != OWNER_NONE) begin
                        action_in = iopt_pkg::ACT_MASK;
                        owner_in  = OWNER_NONE;
                     end
                  end
               end
               iopt_pkg::OP_CHECK: begin
                  if (lk_valid) begin
                     bm_raddr = {lk_slot, start_ff[15:6]};
                     state_in = S_CHECK;
                  end
               end
               iopt_pkg::OP_ADD: begin
                  if (t_in_range) begin
                     state_in = S_ADD_SCAN;
                  end
               end
               iopt_pkg::OP_REVOKE: begin
                  state_in = S_LSCAN_RD;
               end
               iopt_pkg::OP_DROP, iopt_pkg::OP_COUNT: begin
                  if (t_in_range) begin
                     state_in = S_LSCAN_RD;
                  end
               end
               iopt_pkg::OP_RESET: begin
                  claimed_in = '0;
                  owner_in   = OWNER_NONE;
                  active_in  = '0;
                  action_in  = iopt_pkg::ACT_MASK;
               end
               default: begin
               end
            endcase
         end

         S_CLAIM_SCAN: begin
            if (!claimed_ff[sidx_ff]) begin
               claimed_in[sidx_ff]  = 1'b1;
               ts_valid_in[t_idx]   = 1'b1;
               ts_slot_in[t_idx]    = sidx_ff;
               ok_in                = 1'b1;
               state_in             = S_FILL;
            end else if (sidx_ff == SLOT_LAST) begin
               state_in = S_DONE;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end

         S_FILL: begin
            // every port of the new slot starts out denied
            bm_we    = 1'b1;
            bm_waddr = {sidx_ff, fword_ff};
            bm_wdata = {64{1'b1}};
            fword_in = fword_ff + 1'b1;
            if (fword_ff == iopt_pkg::WORD_ADDR_W'(iopt_pkg::WORDS_PER_SLOT - 1)) begin
               state_in = S_DONE;
            end
         end

         S_CHECK: begin
            ok_in    = ~bm_rdata[start_ff[5:0]];
            state_in = S_DONE;
         end

         S_ADD_SCAN: begin
            if (!active_ff[gidx_ff]) begin
               lg_we              = 1'b1;
               active_in[gidx_ff] = 1'b1;
               ok_in              = 1'b1;
               state_in           = S_DONE;
            end else if (gidx_ff == GRANT_LAST) begin
               state_in = S_DONE;
            end else begin
               gidx_in = gidx_ff + 1'b1;
            end
         end

         S_LSCAN_RD: begin
            state_in = S_LSCAN_CHK;
         end

         S_LSCAN_CHK: begin
            state_in = S_LSCAN_NEXT;
            if (active_ff[gidx_ff]) begin
               unique case (op_ff)
                  iopt_pkg::OP_REVOKE: begin
                     if (lg_rdata.cap == cap_ff) begin
                        active_in[gidx_ff] = 1'b0;
                        if (lk_valid) begin
                           rs_slot_in  = lk_slot;
                           rs_start_in = lg_rdata.start;
                           rs_count_in = lg_rdata.count;
                           rs_deny_in  = 1'b1;
                           if (lk_is_owner) begin
                              reload_in      = 1'b1;
                              reload_slot_in = lk_slot;
                           end
                           state_in = S_RANGE_INIT;
                        end
                     end
                  end
                  iopt_pkg::OP_DROP: begin
                     if (lg_rdata.owner == task_ff) begin
                        active_in[gidx_ff] = 1'b0;
                     end
                  end
                  default: begin
                     if (lg_rdata.owner == task_ff && total_ff != iopt_pkg::TOTAL_MAX) begin
                        total_in = total_ff + 5'd1;
                     end
                  end
               endcase
            end
         end

         S_LSCAN_NEXT: begin
            if (gidx_ff == GRANT_LAST) begin
               // reloads of the loaded owner collapse into one load
               if (op_ff == iopt_pkg::OP_REVOKE && reload_ff) begin
                  action_in = iopt_pkg::ACT_LOAD;
                  tslot_in  = 3'(reload_slot_ff);
               end
               state_in = S_DONE;
            end else begin
               gidx_in  = gidx_ff + 1'b1;
               state_in = S_LSCAN_RD;
            end
         end

         S_RANGE_INIT: begin
            if (rs_count_ff == 17'd0) begin
               state_in = (op_ff == iopt_pkg::OP_REVOKE) ? S_LSCAN_NEXT : S_DONE;
            end else begin
               // range end clamps at the top of the port space
               rs_last_in = (rs_sum > 18'(iopt_pkg::PORT_LAST)) ? iopt_pkg::PORT_LAST
                                                                : rs_sum[15:0];
               rs_word_in = rs_start_ff[15:6];
               state_in   = S_RANGE_RD;
            end
         end

         S_RANGE_RD: begin
            state_in = S_RANGE_WR;
         end

         S_RANGE_WR: begin
            bm_we    = 1'b1;
            bm_wdata = rs_deny_ff ? (bm_rdata | rs_mask) : (bm_rdata & ~rs_mask);
            if (rs_word_ff == rs_last_ff[15:6]) begin
               state_in = (op_ff == iopt_pkg::OP_REVOKE) ? S_LSCAN_NEXT : S_DONE;
            end else begin
               rs_word_in = rs_word_ff + 1'b1;
               state_in   = S_RANGE_RD;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tslot_ff, action_ff, 5'(owner_ff), total_ff, ok_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         claimed_ff   <= '0;
         owner_ff     <= OWNER_NONE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            ts_valid_ff[i] <= 1'b0;
            ts_slot_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         claimed_ff   <= claimed_in;
         owner_ff     <= owner_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         ts_valid_ff  <= ts_valid_in;
         ts_slot_ff   <= ts_slot_in;
      end
      op_ff          <= op_in;
      task_ff        <= task_in;
      user_ff        <= user_in;
      start_ff       <= start_in;
      count_ff       <= count_in;
      cap_ff         <= cap_in;
      sidx_ff        <= sidx_in;
      gidx_ff        <= gidx_in;
      fword_ff       <= fword_in;
      rs_slot_ff     <= rs_slot_in;
      rs_start_ff    <= rs_start_in;
      rs_count_ff    <= rs_count_in;
      rs_deny_ff     <= rs_deny_in;
      rs_last_ff     <= rs_last_in;
      rs_word_ff     <= rs_word_in;
      reload_ff      <= reload_in;
      reload_slot_ff <= reload_slot_in;
      ok_ff          <= ok_in;
      total_ff       <= total_in;
      action_ff      <= action_in;
      tslot_ff       <= tslot_in;
      rsp_data_ff    <= rsp_data_in;
   end

   `IOPT_ASSERT_NOW(a_bm_write_state, clock, reset, bm_we,
      (state_ff == S_FILL || state_ff == S_RANGE_WR), "bitmap write outside fill or range")
   `IOPT_ASSERT_NEXT(a_accept_dispatch, clock, reset, accept,
      (state_ff == S_DISPATCH), "accepted transaction not dispatched")
   `IOPT_ASSERT_NEXT(a_reset_op_clears, clock, reset,
      (state_ff == S_DISPATCH && op_ff == iopt_pkg::OP_RESET),
      (claimed_ff == '0 && active_ff == '0 && owner_ff == OWNER_NONE),
      "reset opcode left state behind")
   `IOPT_ASSERT_NOW(a_fill_claimed, clock, reset, (state_ff == S_FILL),
      claimed_ff[sidx_ff], "filling a slot that is not claimed")

endmodule
